// ===== rtl/rrqs_pkg.sv =====
// Shared types and constants for the round-robin quantum scheduler.
// No dependencies; the scheduler top and the test files import this package.
`default_nettype none
package rrqs_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdxW     = $clog2(MaxTasks);
  localparam int unsigned CntW     = $clog2(MaxTasks + 1);

  localparam logic [1:0] FuncTick   = 2'd0;
  localparam logic [1:0] FuncAppend = 2'd1;
  localparam logic [1:0] FuncSetSt  = 2'd2;
  localparam logic [1:0] FuncBad    = 2'd3;

  localparam logic [2:0] StRunnable = 3'd0;
  localparam logic [2:0] StRunning  = 3'd1;
  localparam logic [2:0] StReplaced = 3'd2;
  localparam logic [2:0] StKilled   = 3'd3;
  localparam logic [2:0] StWaiting  = 3'd4;

  typedef struct packed {
    logic [2:0]  state;
    logic [15:0] id;
    logic [15:0] quantum;
    logic [15:0] used;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic        ok;
    logic        rejected;
    logic        unloaded;
    logic [15:0] unload_id;
    logic        loaded;
    logic [15:0] load_id;
    logic [3:0]  load_index;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CUR_RD, S_CUR_CHK, S_KA_RD, S_KA_CHK, S_KB_RD, S_KB_CHK,
    S_SC_INIT, S_SC_RD, S_SC_CHK, S_SS_RD, S_SS_WR, S_RESP
  } fsm_e;

endpackage
`default_nettype wire

// ===== rtl/rrqs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module rrqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/round_robin_quantum_scheduler_top.sv =====
// Top level of the round-robin quantum scheduler: control sequencer around
// one task-table RAM. Depends on rrqs_pkg and rrqs_ram.
`default_nettype none
// Usage:
//   Slave stream carries commands: tuser holds func (tick, append, set state),
//   tdata the entry index, id, quantum and state. Master stream returns one
//   item per command with flags, unload/load ids and the entry count.
//   A tick that compacts the table and then scans it takes longest, since
//   every table entry is visited through the single RAM read port
//   (address, then registered data). The result is presented in the same
//   cycle that the block becomes ready for the next command.
//   One command is processed at a time; the next is accepted once the
//   previous result has been placed in the output register.
//   Reset clears count, current position and the started flag; table
//   contents are not cleared and only written entries are ever read.
//   A stalled receiver holds the output item; the block then waits with the
//   next result until the output register frees up.
module round_robin_quantum_scheduler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [3:0] entry_index, [19:4] proc_id, [35:20] quantum, [38:36] new_state
  input  wire logic [39:0] s_axis_tdata_i,
  // [1:0] func
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] ok, [1] rejected, [2] unloaded, [18:3] unload_id, [19] loaded,
  // [35:20] load_id, [39:36] load_index, [44:40] entry_count
  output logic [47:0]      m_axis_tdata_o
);
  import rrqs_pkg::*;

  fsm_e              state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic              started_q, started_d;
  logic [CntW-1:0]   i_q, i_d;
  logic [CntW-1:0]   w_q, w_d;
  logic [IdxW-1:0]   sidx_q, sidx_d;
  logic [CntW-1:0]   sn_q, sn_d;
  result_t           res_q, res_d;
  logic [39:0]       cmd_q, cmd_d;
  logic [MaxTasks-1:0] kv_q, kv_d;
  logic [15:0]       kid_q [MaxTasks];
  logic              kid_we;
  logic              out_valid_q, out_valid_d;
  logic [47:0]       out_q, out_d;

  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  entry_t            wdata, rdata;
  logic [EntryW-1:0] rdata_raw;
  logic              drop;
  logic [CntW:0]     nxt;
  logic [16:0]       used_inc;

  wire  accept = s_axis_tvalid_i && s_axis_tready_o;
  wire  [3:0]  c_idx   = cmd_q[3:0];
  wire  [2:0]  c_st    = cmd_q[38:36];

  assign rdata = entry_t'(rdata_raw);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  rrqs_ram #(.Width(EntryW), .Depth(MaxTasks)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (EntryW'(wdata)),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // drop test for compaction: replaced, or id of any killed entry
  always_comb begin
    drop = (rdata.state == StReplaced);
    for (int j = 0; j < MaxTasks; j++) begin
      if (kv_q[j] && (kid_q[j] == rdata.id)) drop = 1'b1;
    end
  end

  assign used_inc = {1'b0, rdata.used} + 17'd1;

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    started_d   = started_q;
    i_d         = i_q;
    w_d         = w_q;
    sidx_d      = sidx_q;
    sn_d        = sn_q;
    res_d       = res_q;
    cmd_d       = cmd_q;
    kv_d        = kv_q;
    kid_we      = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rdata;
    raddr       = '0;
    nxt         = '0;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d  = s_axis_tdata_i;
          res_d  = '0;
          state_d = S_RESP;
          case (s_axis_tuser_i)
            FuncAppend: begin
              if (count_q >= CntW'(MaxTasks)) begin
                res_d.rejected = 1'b1;
              end else begin
                we            = 1'b1;
                waddr         = count_q[IdxW-1:0];
                wdata.state   = s_axis_tdata_i[38:36];
                wdata.id      = s_axis_tdata_i[19:4];
                wdata.quantum = s_axis_tdata_i[35:20];
                wdata.used    = '0;
                count_d       = count_q + CntW'(1);
                res_d.ok      = 1'b1;
              end
            end
            FuncSetSt: begin
              if (CntW'(s_axis_tdata_i[3:0]) >= count_q) begin
                res_d.rejected = 1'b1;
              end else begin
                state_d = S_SS_RD;
              end
            end
            FuncTick: begin
              if (count_q != '0) begin
                if (CntW'(cur_q) >= count_q) cur_d = '0;
                if (!started_q) begin
                  sidx_d  = '0;
                  state_d = S_SC_INIT;
                end else begin
                  state_d = S_CUR_RD;
                end
              end
            end
            default: res_d.rejected = 1'b1;
          endcase
        end
      end
      S_SS_RD: begin
        raddr   = c_idx[IdxW-1:0];
        state_d = S_SS_WR;
      end
      S_SS_WR: begin
        we          = 1'b1;
        waddr       = c_idx[IdxW-1:0];
        wdata.state = c_st;
        res_d.ok    = 1'b1;
        state_d     = S_RESP;
      end
      S_CUR_RD: begin
        raddr   = cur_q;
        state_d = S_CUR_CHK;
      end
      S_CUR_CHK: begin
        sidx_d = cur_q;
        if (rdata.state != StRunning) begin
          if (rdata.state == StReplaced || rdata.state == StKilled) begin
            kv_d    = '0;
            i_d     = '0;
            state_d = S_KA_RD;
          end else begin
            res_d.unloaded  = 1'b1;
            res_d.unload_id = rdata.id;
            state_d         = S_SC_INIT;
          end
        end else if (count_q == CntW'(1)) begin
          res_d.ok = 1'b1;
          state_d  = S_RESP;
        end else if (used_inc >= {1'b0, rdata.quantum}) begin
          we              = 1'b1;
          waddr           = cur_q;
          wdata.state     = StRunnable;
          wdata.used      = '0;
          res_d.unloaded  = 1'b1;
          res_d.unload_id = rdata.id;
          state_d         = S_SC_INIT;
        end else begin
          we         = 1'b1;
          waddr      = cur_q;
          wdata.used = used_inc[15:0];
          res_d.ok   = 1'b1;
          state_d    = S_RESP;
        end
      end
      // collect killed ids
      S_KA_RD: begin
        raddr = i_q[IdxW-1:0];
        if (i_q == count_q) begin
          i_d     = '0;
          w_d     = '0;
          state_d = S_KB_RD;
        end else begin
          state_d = S_KA_CHK;
        end
      end
      S_KA_CHK: begin
        kv_d[i_q[IdxW-1:0]] = (rdata.state == StKilled);
        kid_we  = 1'b1;
        i_d     = i_q + CntW'(1);
        state_d = S_KA_RD;
      end
      // move kept entries down
      S_KB_RD: begin
        raddr = i_q[IdxW-1:0];
        if (i_q == count_q) begin
          count_d = w_q;
          state_d = S_SC_INIT;
        end else begin
          state_d = S_KB_CHK;
        end
      end
      S_KB_CHK: begin
        if (!drop) begin
          we    = 1'b1;
          waddr = w_q[IdxW-1:0];
          w_d   = w_q + CntW'(1);
        end
        i_d     = i_q + CntW'(1);
        state_d = S_KB_RD;
      end
      // round-robin scan from the position after sidx
      S_SC_INIT: begin
        nxt     = {1'b0, CntW'(sidx_q)} + (CntW + 1)'(1);
        sidx_d  = (nxt >= {1'b0, count_q}) ? '0 : nxt[IdxW-1:0];
        sn_d    = '0;
        state_d = S_SC_RD;
      end
      S_SC_RD: begin
        raddr = sidx_q;
        if (sn_q >= count_q) begin
          res_d.ok = 1'b0;
          state_d  = S_RESP;
        end else begin
          state_d = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (rdata.state == StRunnable) begin
          we               = 1'b1;
          waddr            = sidx_q;
          wdata.state      = StRunning;
          cur_d            = sidx_q;
          started_d        = 1'b1;
          res_d.ok         = 1'b1;
          res_d.loaded     = 1'b1;
          res_d.load_id    = rdata.id;
          res_d.load_index = 4'(sidx_q);
          state_d          = S_RESP;
        end else begin
          nxt     = {1'b0, CntW'(sidx_q)} + (CntW + 1)'(1);
          sidx_d  = (nxt >= {1'b0, count_q}) ? '0 : nxt[IdxW-1:0];
          sn_d    = sn_q + CntW'(1);
          state_d = S_SC_RD;
        end
      end
      // hand result to the output register once it is free
      S_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_d = {3'b0, 5'(count_q), res_q.load_index, res_q.load_id, res_q.loaded,
                   res_q.unload_id, res_q.unloaded, res_q.rejected, res_q.ok};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      kv_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      kv_q        <= kv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    w_q    <= w_d;
    sidx_q <= sidx_d;
    sn_q   <= sn_d;
    res_q  <= res_d;
    cmd_q  <= cmd_d;
    out_q  <= out_d;
    if (kid_we) kid_q[i_q[IdxW-1:0]] <= rdata.id;
  end

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxTasks))
    else $error("entry count beyond table size");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("output item changed while stalled");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && state_d == S_IDLE) |=> m_axis_tvalid_o)
    else $error("finished item not presented");
  a_compact_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KB_RD && i_q == count_q) |-> (w_q <= count_q))
    else $error("compaction grew the table");
  a_reject_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("item both accepted and rejected");

endmodule
`default_nettype wire

// ===== test/rrqs_checker.sv =====
// Scoreboard for the round-robin quantum scheduler: watches both streams,
// predicts each result from its own copy of the task table. Depends on rrqs_pkg.
`timescale 1ns / 100ps
module rrqs_checker
  import rrqs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [39:0] s_data_i,
  input  wire logic [1:0]  s_user_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [47:0] m_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               loads_o
);

  typedef struct packed {
    logic        ok;
    logic        rejected;
    logic        unloaded;
    logic [15:0] unload_id;
    logic        loaded;
    logic [15:0] load_id;
    logic [3:0]  load_index;
    logic [4:0]  entry_count;
  } sched_result_t;

  logic [2:0]  tbl_state [MaxTasks];
  logic [15:0] tbl_id    [MaxTasks];
  logic [15:0] tbl_quant [MaxTasks];
  logic [15:0] tbl_used  [MaxTasks];
  int unsigned n_entries;
  int unsigned cur_pos;
  bit          running_seen;
  sched_result_t expected_q[$];

  assign pending_o = expected_q.size();

  // Round-robin search for a runnable entry after position from
  function automatic bit pick_next(int unsigned from);
    int unsigned idx;
    idx = from + 1;
    for (int unsigned n = 0; n < n_entries; n++) begin
      if (idx >= n_entries) idx = 0;
      if (tbl_state[idx] == StRunnable) begin
        tbl_state[idx] = StRunning;
        cur_pos = idx;
        running_seen = 1'b1;
        return 1'b1;
      end
      idx++;
    end
    return 1'b0;
  endfunction

  // Drop replaced entries and every entry sharing a killed id, keeping order
  function automatic void squeeze_table();
    bit drop [MaxTasks];
    int unsigned w;
    w = 0;
    for (int unsigned i = 0; i < n_entries; i++) begin
      drop[i] = (tbl_state[i] == StReplaced);
      for (int unsigned j = 0; j < n_entries; j++)
        if (tbl_state[j] == StKilled && tbl_id[j] == tbl_id[i]) drop[i] = 1'b1;
    end
    for (int unsigned i = 0; i < n_entries; i++) begin
      if (!drop[i]) begin
        tbl_state[w] = tbl_state[i];
        tbl_id[w]    = tbl_id[i];
        tbl_quant[w] = tbl_quant[i];
        tbl_used[w]  = tbl_used[i];
        w++;
      end
    end
    n_entries = w;
  endfunction

  function automatic sched_result_t schedule_item(logic [1:0] func, logic [39:0] d);
    sched_result_t r;
    logic [3:0]  eidx;
    logic [15:0] pid, quant;
    logic [2:0]  nst, s;
    int unsigned u;
    bit rescan;
    r = '0;
    rescan = 1'b0;
    eidx  = d[3:0];
    pid   = d[19:4];
    quant = d[35:20];
    nst   = d[38:36];
    if (func == FuncAppend) begin
      if (n_entries >= MaxTasks) r.rejected = 1'b1;
      else begin
        tbl_state[n_entries] = nst;
        tbl_id[n_entries]    = pid;
        tbl_quant[n_entries] = quant;
        tbl_used[n_entries]  = '0;
        n_entries++;
        r.ok = 1'b1;
      end
    end else if (func == FuncSetSt) begin
      if (eidx >= n_entries) r.rejected = 1'b1;
      else begin
        tbl_state[eidx] = nst;
        r.ok = 1'b1;
      end
    end else if (func != FuncTick) begin
      r.rejected = 1'b1;
    end else if (n_entries != 0) begin
      if (cur_pos >= n_entries) cur_pos = 0;
      if (!running_seen) begin
        r.ok = pick_next(0);
        r.loaded = r.ok;
      end else if (tbl_state[cur_pos] != StRunning) begin
        s = tbl_state[cur_pos];
        if (s == StReplaced || s == StKilled) squeeze_table();
        else begin
          r.unloaded = 1'b1;
          r.unload_id = tbl_id[cur_pos];
        end
        rescan = 1'b1;
      end else if (n_entries == 1) begin
        r.ok = 1'b1;
      end else begin
        u = tbl_used[cur_pos] + 1;
        if (u >= tbl_quant[cur_pos]) begin
          tbl_state[cur_pos] = StRunnable;
          tbl_used[cur_pos] = '0;
          r.unloaded = 1'b1;
          r.unload_id = tbl_id[cur_pos];
          rescan = 1'b1;
        end else begin
          tbl_used[cur_pos] = u[15:0];
          r.ok = 1'b1;
        end
      end
      if (rescan) begin
        r.ok = pick_next(cur_pos);
        r.loaded = r.ok;
      end
    end
    if (r.loaded) begin
      r.load_id = tbl_id[cur_pos];
      r.load_index = cur_pos[3:0];
    end
    r.entry_count = n_entries[4:0];
    return r;
  endfunction

  // Predict on accepted items, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t got, want;
    if (!rst_ni) begin
      n_entries = 0;
      cur_pos = 0;
      running_seen = 1'b0;
      expected_q.delete();
      fail_count_o <= 0;
      loads_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = {m_data_i[0], m_data_i[1], m_data_i[2], m_data_i[18:3], m_data_i[19],
               m_data_i[35:20], m_data_i[39:36], m_data_i[44:40]};
        if (expected_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %h", m_data_i);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected %p, got %p", want, got);
          end
          if (want.loaded) loads_o <= loads_o + 1;
        end
      end
      if (s_valid_i && s_ready_i) expected_q.push_back(schedule_item(s_user_i, s_data_i));
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the round-robin quantum scheduler: drives command items
// with bursts and gaps, stalls the result side, and reports the verdict.
// Depends on rrqs_pkg, rrqs_checker and the scheduler RTL.
`timescale 1ns / 100ps
module tb;
  import rrqs_pkg::*;

  logic        clk, rst_n;
  logic        s_valid, s_ready, m_valid, m_ready;
  logic [39:0] s_data;
  logic [1:0]  s_user;
  logic [47:0] m_data;
  int          fails, pending, loads, idle_cycles;
  int          accepted;
  int unsigned known_count;

  round_robin_quantum_scheduler_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data)
  );

  rrqs_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .fail_count_o(fails), .pending_o(pending), .loads_o(loads)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stall pattern: calm stretches alternate with heavy stalling
  initial begin
    m_ready = 1'b0;
    forever begin
      @(posedge clk);
      if ((accepted / 150) % 3 == 0) m_ready <= 1'b1;
      else m_ready <= ($urandom_range(0, 3) != 0) ? ~m_ready : m_ready;
    end
  end

  // Watchdog: cycles with no item moving on either side
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("[round_robin_quantum_scheduler_top] ERROR");
        $finish;
      end
    end
  end

  // Hand one item over and hold until it is taken
  task automatic send_cmd(logic [1:0] func, logic [3:0] eidx, logic [15:0] pid,
                          logic [15:0] quant, logic [2:0] st);
    s_valid <= 1'b1;
    s_user  <= func;
    s_data  <= {1'b0, st, quant, pid, eidx};
    do @(posedge clk); while (!s_ready);
    accepted++;
    if (func == FuncAppend && known_count < MaxTasks) known_count++;
  endtask

  task automatic gap_cycles(int n);
    if (n > 0) begin
      s_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random command: mostly ticks and set-state within the table
  task automatic random_cmd(int unsigned id_pool);
    int unsigned r;
    logic [15:0] pid, q;
    r = $urandom_range(0, 99);
    pid = (id_pool == 0) ? 16'($urandom) : 16'($urandom_range(0, id_pool));
    q = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    if (r < 45) send_cmd(FuncTick, 4'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
    else if (r < 65)
      send_cmd(FuncAppend, 4'($urandom), pid, q,
               ($urandom_range(0, 3) == 0) ? 3'($urandom) : StRunnable);
    else if (r < 97)
      send_cmd(FuncSetSt, ($urandom_range(0, 9) == 0) ? 4'($urandom)
                          : 4'($urandom_range(0, (known_count > 0) ? known_count - 1 : 0)),
               16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)));
    else send_cmd(FuncBad, 4'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
  endtask

  initial begin
    int burst;
    rst_n = 1'b0;
    s_valid = 1'b0;
    s_user = '0;
    s_data = '0;
    accepted = 0;
    known_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, bad func, rejects, extremes, kill and replace
    send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncBad, 4'hf, 16'hffff, 16'hffff, 3'd7);
    send_cmd(FuncSetSt, 4'd0, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncAppend, 4'hf, 16'hffff, 16'hffff, StRunnable);
    send_cmd(FuncAppend, 4'd0, 16'h0000, 16'd0, StRunnable);
    send_cmd(FuncAppend, 4'd0, 16'h1234, 16'd2, 3'd7);
    send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncSetSt, 4'd2, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncSetSt, 4'd1, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncSetSt, 4'd1, 16'd0, 16'd0, StWaiting);
    send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
    for (int i = 0; i < 14; i++)
      send_cmd(FuncAppend, 4'd0, 16'(i % 3), 16'd1, StRunnable);
    send_cmd(FuncAppend, 4'd0, 16'd9, 16'd9, StRunnable);
    send_cmd(FuncSetSt, 4'hf, 16'd0, 16'd0, StReplaced);
    send_cmd(FuncSetSt, 4'd3, 16'd0, 16'd0, StKilled);
    send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
    send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
    drain_results();
    // Hold off until everything is back, then let the block settle
    repeat (80) @(posedge clk);

    // Random part in bursts; the table empties itself through replacements
    while (accepted < 1000) begin
      burst = $urandom_range(1, 20);
      repeat (burst) random_cmd(($urandom_range(0, 3) == 0) ? 0 : 5);
      if ($urandom_range(0, 2) == 0) gap_cycles($urandom_range(1, 12));
      if ($urandom_range(0, 30) == 0) begin
        drain_results();
        known_count = 0;
        // Replace everything that could be left so counts stay realistic
        for (int i = 0; i < 16; i++)
          send_cmd(FuncSetSt, 4'(i), 16'd0, 16'd0, StReplaced);
        repeat (20) send_cmd(FuncTick, 4'd0, 16'd0, 16'd0, StRunnable);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("Ran %0d command items (ticks, appends, set-state, bad func); %0d loads seen.",
             accepted, loads);
    if (fails == 0 && pending == 0) $display("[round_robin_quantum_scheduler_top] OK");
    else $display("[round_robin_quantum_scheduler_top] ERROR");
    $finish;
  end

endmodule
